FILE: hdl/mpd_pkg.sv
// Shared types and constants of the MQTT packet deframer.
// No dependencies; used by mpd_front, mpd_back and the top module.
`default_nettype none
package mpd_pkg;

  // Parse phase codes, also reported on the phase output field
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Register map
  localparam logic [2:0]  REG_BUFFER_SIZE   = 3'd0;
  localparam logic [15:0] BUFFER_SIZE_RESET = 16'd512;

  // Remaining-length byte layout
  localparam int unsigned CONT_BIT   = 7;
  localparam int unsigned GROUP_BITS = 7;

  // One queued byte, classified by the front part
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       cont;      // continuation bit of a length byte
    logic [6:0] group;     // 7-bit length group
  } entry_t;

  // One result item
  typedef struct packed {
    logic [7:0]  stored_byte;
    logic        store_enable;
    logic [15:0] store_addr;
    logic [1:0]  phase;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [2:0]  length_bytes;
    logic [27:0] remaining_length;
    logic        packet_end;
    logic        packet_kept;
    logic [15:0] stored_length;
    logic        length_error;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/mpd_if.sv
// Valid/ready channel interfaces of the deframer: received bytes and results.
// Depends on nothing; widths follow the item fields.
`default_nettype none
interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  stored_byte;
  logic        store_enable;
  logic [15:0] store_addr;
  logic [1:0]  phase;
  logic [3:0]  packet_type;
  logic [3:0]  header_flags;
  logic [2:0]  length_bytes;
  logic [27:0] remaining_length;
  logic        packet_end;
  logic        packet_kept;
  logic [15:0] stored_length;
  logic        length_error;

  modport source (output valid, output stored_byte, output store_enable, output store_addr,
                  output phase, output packet_type, output header_flags, output length_bytes,
                  output remaining_length, output packet_end, output packet_kept,
                  output stored_length, output length_error, input ready);
  modport sink   (input valid, input stored_byte, input store_enable, input store_addr,
                  input phase, input packet_type, input header_flags, input length_bytes,
                  input remaining_length, input packet_end, input packet_kept,
                  input stored_length, input length_error, output ready);
endinterface
`default_nettype wire

FILE: hdl/mpd_front.sv
// Front part: accepts received bytes, classifies them and holds them in a
// two-entry queue toward the parser. Depends on mpd_pkg.
`default_nettype none
module mpd_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [7:0]        in_byte_i,
  output logic              q_valid_o,
  input  wire               q_pop_i,
  output mpd_pkg::entry_t   q_entry_o
);

  mpd_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push, pop;
  mpd_pkg::entry_t entry;

  always_comb begin
    entry.rx_byte = in_byte_i;
    entry.cont    = in_byte_i[mpd_pkg::CONT_BIT];
    entry.group   = in_byte_i[mpd_pkg::GROUP_BITS-1:0];
  end

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mpd_back.sv
// Back part: runs the packet parser on queued bytes and registers one result
// per byte for the output channel. Depends on mpd_pkg.
`default_nettype none
module mpd_back #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int STORE_ADDR_WIDTH = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [15:0]       buffer_size_i,
  input  wire               q_valid_i,
  output logic              q_pop_o,
  input  mpd_pkg::entry_t   q_entry_i,
  output logic              res_valid_o,
  input  wire               res_ready_i,
  output mpd_pkg::result_t  res_o
);

  localparam int LW = STORE_ADDR_WIDTH + 1;

  logic [1:0]       phase_q, phase_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [2:0]       gcnt_q, gcnt_d;
  logic [27:0]      acc_q, acc_d;
  logic [27:0]      left_q, left_d;
  logic [28:0]      total_q, total_d;
  logic [LW-1:0]    sc_q, sc_d;
  logic             res_valid_q;
  mpd_pkg::result_t res_q, res_d;

  logic             is_hdr;
  logic [1:0]       ph;
  logic [2:0]       g_base;
  logic [27:0]      acc_base, left_base;
  logic [28:0]      total_base;
  logic [LW-1:0]    sc_base, limit;
  logic [16:0]      buf_ext, cap, lim_full;
  logic             en, pkt_end, kept, err;
  logic [4:0]       shift;

  assign q_pop_o = q_valid_i && (!res_valid_q || res_ready_i);

  // Store limit is the smaller of buffer size and the address space
  always_comb begin
    buf_ext  = {1'b0, buffer_size_i};
    cap      = 17'd1 << STORE_ADDR_WIDTH;
    lim_full = (buf_ext < cap) ? buf_ext : cap;
    limit    = lim_full[LW-1:0];
  end

  always_comb begin
    is_hdr     = (phase_q == mpd_pkg::PH_HEADER);
    hdr_d      = is_hdr ? q_entry_i.rx_byte : hdr_q;
    g_base     = is_hdr ? 3'd0 : gcnt_q;
    acc_base   = is_hdr ? 28'd0 : acc_q;
    left_base  = is_hdr ? 28'd0 : left_q;
    total_base = is_hdr ? 29'd0 : total_q;
    sc_base    = is_hdr ? '0 : sc_q;

    en      = (sc_base < limit);
    sc_d    = sc_base + LW'(en);
    total_d = total_base + 29'd1;

    gcnt_d  = g_base;
    acc_d   = acc_base;
    left_d  = left_base;
    phase_d = phase_q;
    pkt_end = 1'b0;
    err     = 1'b0;
    shift   = 5'd0;

    case (phase_q)
      mpd_pkg::PH_HEADER: ph = mpd_pkg::PH_HEADER;
      mpd_pkg::PH_LENGTH: ph = mpd_pkg::PH_LENGTH;
      default:            ph = mpd_pkg::PH_BODY;
    endcase

    case (g_base[1:0])
      2'd0:    shift = 5'd0;
      2'd1:    shift = 5'd7;
      2'd2:    shift = 5'd14;
      default: shift = 5'd21;
    endcase

    case (ph)
      mpd_pkg::PH_HEADER: begin
        phase_d = mpd_pkg::PH_LENGTH;
      end
      mpd_pkg::PH_LENGTH: begin
        acc_d  = acc_base + ({21'd0, q_entry_i.group} << shift);
        gcnt_d = g_base + 3'd1;
        if (q_entry_i.cont) begin
          // Too many length groups: flag and resync on the next byte
          if (gcnt_d >= 3'(MAX_LENGTH_BYTES)) begin
            err     = 1'b1;
            phase_d = mpd_pkg::PH_HEADER;
          end
        end else if (acc_d == 28'd0) begin
          pkt_end = 1'b1;
          phase_d = mpd_pkg::PH_HEADER;
        end else begin
          left_d  = acc_d;
          phase_d = mpd_pkg::PH_BODY;
        end
      end
      default: begin
        if (left_base != 28'd0) begin
          left_d = left_base - 28'd1;
        end
        if (left_d == 28'd0) begin
          pkt_end = 1'b1;
          phase_d = mpd_pkg::PH_HEADER;
        end
      end
    endcase

    kept = pkt_end && (total_d <= 29'(limit));

    res_d.stored_byte      = q_entry_i.rx_byte;
    res_d.store_enable     = en;
    res_d.store_addr       = 16'(sc_base[STORE_ADDR_WIDTH-1:0]);
    res_d.phase            = ph;
    res_d.packet_type      = hdr_d[7:4];
    res_d.header_flags     = hdr_d[3:0];
    res_d.length_bytes     = gcnt_d;
    res_d.remaining_length = acc_d;
    res_d.packet_end       = pkt_end;
    res_d.packet_kept      = kept;
    res_d.stored_length    = kept ? 16'(sc_d) : 16'd0;
    res_d.length_error     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mpd_pkg::PH_HEADER;
      hdr_q       <= 8'd0;
      gcnt_q      <= 3'd0;
      acc_q       <= 28'd0;
      left_q      <= 28'd0;
      total_q     <= 29'd0;
      sc_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q     <= phase_d;
        hdr_q       <= hdr_d;
        gcnt_q      <= gcnt_d;
        acc_q       <= acc_d;
        left_q      <= left_d;
        total_q     <= total_d;
        sc_q        <= sc_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: hdl/mqtt_packet_deframer.sv
// MQTT packet deframer, one received byte in and one result item out per cycle
// unless the output stalls. A front queue of two bytes decouples input from
// the parser; an output register holds each result until taken. Each byte is
// registered in the front queue, its result in the output register. Throughput
// is set by the parser update in the back part. buffer_size sits at APB
// address 0. Depends on mpd_pkg, mpd_if, mpd_front and mpd_back.
`default_nettype none
module mqtt_packet_deframer #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int STORE_ADDR_WIDTH = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  mpd_in_if.sink        rx_i,
  mpd_out_if.source     res_o,
  input  wire           psel,
  input  wire           penable,
  input  wire           pwrite,
  input  wire  [2:0]    paddr,
  input  wire  [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [15:0]      buffer_size_q, buffer_size_d;
  logic             q_valid, q_pop;
  mpd_pkg::entry_t  q_entry;
  mpd_pkg::result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == mpd_pkg::REG_BUFFER_SIZE) ? {16'd0, buffer_size_q} : 32'd0;

  always_comb begin
    buffer_size_d = buffer_size_q;
    if (psel && penable && pwrite && (paddr == mpd_pkg::REG_BUFFER_SIZE)) begin
      buffer_size_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= mpd_pkg::BUFFER_SIZE_RESET;
    end else begin
      buffer_size_q <= buffer_size_d;
    end
  end

  mpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .in_byte_i  (rx_i.rx_byte),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_entry_o  (q_entry)
  );

  mpd_back #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
    .STORE_ADDR_WIDTH (STORE_ADDR_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .buffer_size_i (buffer_size_q),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_entry_i     (q_entry),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_o         (res)
  );

  assign res_o.stored_byte      = res.stored_byte;
  assign res_o.store_enable     = res.store_enable;
  assign res_o.store_addr       = res.store_addr;
  assign res_o.phase            = res.phase;
  assign res_o.packet_type      = res.packet_type;
  assign res_o.header_flags     = res.header_flags;
  assign res_o.length_bytes     = res.length_bytes;
  assign res_o.remaining_length = res.remaining_length;
  assign res_o.packet_end       = res.packet_end;
  assign res_o.packet_kept      = res.packet_kept;
  assign res_o.stored_length    = res.stored_length;
  assign res_o.length_error     = res.length_error;

endmodule
`default_nettype wire
